FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the PPM and servo PWM block.
// Each use stands on a line of its own; the messages are fixed text.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define PPMSG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ppmsg check failed");

// Clocked check that also holds across reset.
`define PPMSG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ppmsg reset check failed");

`endif

FILE: src/ppmsg_pkg.sv
// Package of the PPM frame and servo PWM generator: field widths, register
// indexes, reset values and the structs passed between its modules. No dependencies.
`default_nettype none

package ppmsg_pkg;

  localparam int WIDTH_W     = 16;
  localparam int CH_W        = 4;
  localparam int SLOT_IDX_W  = 5;
  localparam int ACT_W       = 5;
  localparam int SERVO_OUT_W = 12;
  localparam int CFG_IDX_W   = 8;
  localparam int LIMIT_W     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP        = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PPM_PULSE       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_PERIOD    = 8'd3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [ACT_W-1:0]   RST_ACTIVE_CHANNELS = 5'd12;
  localparam logic [WIDTH_W-1:0] RST_SYNC_GAP        = 16'd3000;
  localparam logic [WIDTH_W-1:0] RST_PPM_PULSE       = 16'd300;
  localparam logic [WIDTH_W-1:0] RST_SERVO_PERIOD    = 16'd20000;
  localparam logic [WIDTH_W-1:0] RST_SERVO_COMPARE   = 16'd1000;
  localparam logic [WIDTH_W-1:0] RST_SLOT_LENGTH     = 16'd1000;

  typedef struct packed {
    logic [ACT_W-1:0]   active_channels;
    logic [WIDTH_W-1:0] sync_gap;
    logic [WIDTH_W-1:0] ppm_pulse;
    logic [WIDTH_W-1:0] servo_period;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic [CH_W-1:0]    channel;
    logic [WIDTH_W-1:0] width;
  } item_t;

  typedef struct packed {
    logic               wr_en;
    logic               tick;
    logic [CH_W-1:0]    channel;
    logic [WIDTH_W-1:0] width;
  } step_t;

endpackage

`default_nettype wire

FILE: src/ppmsg_ifs.sv
// Valid/ready channel interfaces of the PPM and servo PWM generator:
// input items, result items and configuration writes. Uses ppmsg_pkg.
`default_nettype none

interface ppmsg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ppmsg_pkg::CH_W-1:0]    channel;
  logic [ppmsg_pkg::WIDTH_W-1:0] width;
  modport source (output valid, output req_type, output channel, output width, input ready);
  modport sink   (input valid, input req_type, input channel, input width, output ready);
endinterface

interface ppmsg_out_if;
  logic                              valid;
  logic                              ready;
  logic                              ppm_level;
  logic [ppmsg_pkg::SERVO_OUT_W-1:0] servo_levels;
  logic                              frame_start;
  modport source (output valid, output ppm_level, output servo_levels, output frame_start,
                  input ready);
  modport sink   (input valid, input ppm_level, input servo_levels, input frame_start,
                  output ready);
endinterface

interface ppmsg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ppmsg_pkg::CFG_IDX_W-1:0] index;
  logic [ppmsg_pkg::WIDTH_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/ppmsg_servo.sv
// Servo PWM unit: shared period counter, compare preloads and active compares.
// Uses ppmsg_pkg.
`default_nettype none

module ppmsg_servo #(
  parameter int NUM_SERVOS = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ppmsg_pkg::step_t                  step,
  input  wire logic [ppmsg_pkg::WIDTH_W-1:0]     servo_period,
  output logic      [ppmsg_pkg::SERVO_OUT_W-1:0] servo_levels
);

  logic [ppmsg_pkg::WIDTH_W-1:0] preload_r [NUM_SERVOS];
  logic [ppmsg_pkg::WIDTH_W-1:0] active_r  [NUM_SERVOS];
  logic [ppmsg_pkg::WIDTH_W-1:0] count_r;
  logic [ppmsg_pkg::WIDTH_W-1:0] count_nxt;
  logic [ppmsg_pkg::WIDTH_W:0]   count_inc;
  logic                          wrap;

  always_comb begin
    count_inc = {1'b0, count_r} + 17'd1;
    wrap      = count_inc >= {1'b0, servo_period};
    count_nxt = wrap ? '0 : count_inc[ppmsg_pkg::WIDTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step.tick) begin
      count_r <= count_nxt;
    end
  end

  for (genvar g = 0; g < NUM_SERVOS; g++) begin : g_servo
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        preload_r[g] <= ppmsg_pkg::RST_SERVO_COMPARE;
        active_r[g]  <= ppmsg_pkg::RST_SERVO_COMPARE;
      end else begin
        if (step.wr_en && (step.channel == ppmsg_pkg::CH_W'(g))) begin
          preload_r[g] <= step.width;
        end
        if (step.tick && wrap) begin
          active_r[g] <= preload_r[g];
        end
      end
    end
  end

  for (genvar b = 0; b < ppmsg_pkg::SERVO_OUT_W; b++) begin : g_level
    if (b < NUM_SERVOS) begin : g_used
      assign servo_levels[b] = count_r < active_r[b];
    end else begin : g_unused
      assign servo_levels[b] = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: src/ppmsg_ppm.sv
// PPM frame unit: channel width store, slot counter, slot length and slot index.
// Uses ppmsg_pkg.
`default_nettype none

module ppmsg_ppm #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ppmsg_pkg::step_t step,
  input  wire ppmsg_pkg::cfg_t  cfg,
  output logic                  ppm_level,
  output logic                  frame_start
);

  localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [ppmsg_pkg::WIDTH_W-1:0]    store_r [NUM_SLOTS];
  logic [ppmsg_pkg::WIDTH_W-1:0]    count_r;
  logic [ppmsg_pkg::WIDTH_W-1:0]    count_nxt;
  logic [ppmsg_pkg::WIDTH_W:0]      count_inc;
  logic [ppmsg_pkg::WIDTH_W-1:0]    len_r;
  logic [ppmsg_pkg::WIDTH_W-1:0]    len_nxt;
  logic [ppmsg_pkg::SLOT_IDX_W-1:0] idx_r;
  logic [ppmsg_pkg::SLOT_IDX_W-1:0] idx_nxt;
  logic [ppmsg_pkg::LIMIT_W-1:0]    limit;
  logic                             pulse_end;
  logic                             in_frame;

  always_comb begin
    count_inc = {1'b0, count_r} + 17'd1;
    count_nxt = (count_inc >= {1'b0, len_r}) ? '0 : count_inc[ppmsg_pkg::WIDTH_W-1:0];
    pulse_end = count_nxt == cfg.ppm_pulse;
    limit     = (ppmsg_pkg::LIMIT_W'(cfg.active_channels) > ppmsg_pkg::LIMIT_W'(NUM_SLOTS)) ?
                ppmsg_pkg::LIMIT_W'(NUM_SLOTS) : ppmsg_pkg::LIMIT_W'(cfg.active_channels);
    in_frame  = ppmsg_pkg::LIMIT_W'(idx_r) < limit;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    if (pulse_end) begin
      if (in_frame) begin
        len_nxt = store_r[idx_r[SLOT_AW-1:0]];
        idx_nxt = idx_r + 5'd1;
      end else begin
        len_nxt = cfg.sync_gap;
        idx_nxt = '0;
      end
    end
    ppm_level   = count_r < cfg.ppm_pulse;
    frame_start = step.tick && pulse_end && !in_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      len_r   <= ppmsg_pkg::RST_SLOT_LENGTH;
      idx_r   <= '0;
    end else if (step.tick) begin
      count_r <= count_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
    end
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_store
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        store_r[g] <= '0;
      end else if (step.wr_en &&
                   (ppmsg_pkg::SLOT_IDX_W'(step.channel) == ppmsg_pkg::SLOT_IDX_W'(g))) begin
        store_r[g] <= step.width;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/ppm_frame_and_servo_pwm_generator.sv
// Top level of the PPM frame and servo PWM generator: channels, input and result
// registers, configuration registers. Uses ppmsg_pkg, ppmsg_ifs, ppmsg_servo, ppmsg_ppm.
//
// Each item is a channel write or one timebase tick and gives exactly one result item
// with the PPM level and servo levels as they stood before the item, plus a frame start
// flag. An item passes an input register and a result register. One item is accepted
// per cycle while the result side takes items; the counters and stores update in one
// pass between the two registers. Configuration writes are taken in any cycle and
// should be made while no item is in flight.
`default_nettype none

module ppm_frame_and_servo_pwm_generator #(
  parameter int NUM_SLOTS  = 16,
  parameter int NUM_SERVOS = 12
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  ppmsg_in_if.sink      in_if,
  ppmsg_out_if.source   out_if,
  ppmsg_cfg_if.sink     cfg_if
);

  ppmsg_pkg::cfg_t                  cfg_r;
  ppmsg_pkg::item_t                 s1_item_r;
  logic                             s1_valid_r;
  logic                             advance;
  logic                             in_acc;
  ppmsg_pkg::step_t                 step;
  logic                             ppm_level;
  logic                             frame_start;
  logic [ppmsg_pkg::SERVO_OUT_W-1:0] servo_levels;
  logic                             out_valid_r;
  logic                             ppm_level_r;
  logic                             frame_start_r;
  logic [ppmsg_pkg::SERVO_OUT_W-1:0] servo_levels_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_channels <= ppmsg_pkg::RST_ACTIVE_CHANNELS;
      cfg_r.sync_gap        <= ppmsg_pkg::RST_SYNC_GAP;
      cfg_r.ppm_pulse       <= ppmsg_pkg::RST_PPM_PULSE;
      cfg_r.servo_period    <= ppmsg_pkg::RST_SERVO_PERIOD;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        ppmsg_pkg::REG_ACTIVE_CHANNELS:
          cfg_r.active_channels <= cfg_if.data[ppmsg_pkg::ACT_W-1:0];
        ppmsg_pkg::REG_SYNC_GAP:     cfg_r.sync_gap     <= cfg_if.data;
        ppmsg_pkg::REG_PPM_PULSE:    cfg_r.ppm_pulse    <= cfg_if.data;
        ppmsg_pkg::REG_SERVO_PERIOD: cfg_r.servo_period <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign in_acc      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.req_type <= in_if.req_type;
      s1_item_r.channel  <= in_if.channel;
      s1_item_r.width    <= in_if.width;
    end
  end

  always_comb begin
    step.wr_en   = advance && (s1_item_r.req_type == ppmsg_pkg::REQ_WRITE);
    step.tick    = advance && (s1_item_r.req_type == ppmsg_pkg::REQ_TICK);
    step.channel = s1_item_r.channel;
    step.width   = s1_item_r.width;
  end

  ppmsg_servo #(
    .NUM_SERVOS (NUM_SERVOS)
  ) u_servo (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .servo_period (cfg_r.servo_period),
    .servo_levels (servo_levels)
  );

  ppmsg_ppm #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ppm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .cfg         (cfg_r),
    .ppm_level   (ppm_level),
    .frame_start (frame_start)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ppm_level_r    <= ppm_level;
      servo_levels_r <= servo_levels;
      frame_start_r  <= frame_start;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.ppm_level    = ppm_level_r;
  assign out_if.servo_levels = servo_levels_r;
  assign out_if.frame_start  = frame_start_r;

endmodule

`default_nettype wire

FILE: src/ppmsg_checker.sv
// Port-level checker of the PPM frame and servo PWM generator and its bind.
// Depends on assert_macros.svh, ppmsg_pkg and the top level.
`default_nettype none
`include "assert_macros.svh"

module ppmsg_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              out_ppm_level,
  input wire logic [ppmsg_pkg::SERVO_OUT_W-1:0] out_servo_levels,
  input wire logic                              out_frame_start
);

  logic [1:0] inflight_r;
  logic [1:0] inflight_nxt;
  logic       in_acc;
  logic       out_acc;
  logic       out_stall;
  logic [ppmsg_pkg::SERVO_OUT_W+1:0] out_payload;

  assign in_acc      = in_valid && in_ready;
  assign out_acc     = out_valid && out_ready;
  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_ppm_level, out_servo_levels, out_frame_start};

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      inflight_nxt = inflight_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  `PPMSG_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)
  `PPMSG_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_payload))
  `PPMSG_ASSERT(a_no_stall_when_drained, clk, rst_n, out_ready |-> in_ready)
  `PPMSG_ASSERT(a_inflight_bound, clk, rst_n, inflight_r != 2'd3)
  `PPMSG_ASSERT(a_result_has_item, clk, rst_n, out_valid |-> inflight_r != 2'd0)

endmodule

bind ppm_frame_and_servo_pwm_generator ppmsg_checker u_ppmsg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_ppm_level    (out_if.ppm_level),
  .out_servo_levels (out_if.servo_levels),
  .out_frame_start  (out_if.frame_start)
);

`default_nettype wire

FILE: test/ppm_frame_and_servo_pwm_generator_tb.sv
// Self-checking testbench of the PPM frame and servo PWM generator: directed corner items,
// then randomized phases with differing register settings, most idling randomly on both sides.
// Depends on ppmsg_pkg, the ppmsg channel interfaces and the generator top level.
`default_nettype none

module ppm_frame_and_servo_pwm_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS      = 16;
  localparam int NUM_SERVOS     = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 150;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [ppmsg_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST =
    ppmsg_pkg::REG_SERVO_PERIOD + 1'b1;
  localparam logic [ppmsg_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

  typedef struct packed {
    logic                              ppm_level;
    logic [ppmsg_pkg::SERVO_OUT_W-1:0] servo_levels;
    logic                              frame_start;
  } levels_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ppmsg_in_if  in_ch();
  ppmsg_out_if out_ch();
  ppmsg_cfg_if cfg_ch();

  ppm_frame_and_servo_pwm_generator #(
    .NUM_SLOTS (NUM_SLOTS),
    .NUM_SERVOS(NUM_SERVOS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  ppmsg_pkg::cfg_t                 live_cfg;
  logic [ppmsg_pkg::WIDTH_W-1:0]   chan_width    [NUM_SLOTS];
  logic [ppmsg_pkg::WIDTH_W-1:0]   servo_shadow  [NUM_SERVOS];
  logic [ppmsg_pkg::WIDTH_W-1:0]   servo_compare [NUM_SERVOS];
  int unsigned                     servo_ticks;
  int unsigned                     ppm_ticks;
  int unsigned                     slot_len;
  int unsigned                     slot_num;

  levels_t levels_q[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      no_idle = 1'b0;

  function automatic void reset_levels_model();
    live_cfg.active_channels = ppmsg_pkg::RST_ACTIVE_CHANNELS;
    live_cfg.sync_gap        = ppmsg_pkg::RST_SYNC_GAP;
    live_cfg.ppm_pulse       = ppmsg_pkg::RST_PPM_PULSE;
    live_cfg.servo_period    = ppmsg_pkg::RST_SERVO_PERIOD;
    for (int i = 0; i < NUM_SLOTS; i++) chan_width[i] = '0;
    for (int i = 0; i < NUM_SERVOS; i++) begin
      servo_shadow[i]  = ppmsg_pkg::RST_SERVO_COMPARE;
      servo_compare[i] = ppmsg_pkg::RST_SERVO_COMPARE;
    end
    servo_ticks = 0;
    ppm_ticks   = 0;
    slot_len    = ppmsg_pkg::RST_SLOT_LENGTH;
    slot_num    = 0;
  endfunction

  function automatic levels_t advance_levels(ppmsg_pkg::item_t it);
    levels_t     r;
    int unsigned lim;
    r.ppm_level    = (ppm_ticks < live_cfg.ppm_pulse);
    r.servo_levels = '0;
    for (int i = 0; i < NUM_SERVOS && i < ppmsg_pkg::SERVO_OUT_W; i++)
      r.servo_levels[i] = (servo_ticks < servo_compare[i]);
    r.frame_start  = 1'b0;
    if (it.req_type == ppmsg_pkg::REQ_WRITE) begin
      if (it.channel < NUM_SLOTS) chan_width[it.channel] = it.width;
      if (it.channel < NUM_SERVOS) servo_shadow[it.channel] = it.width;
    end else begin
      servo_ticks++;
      if (servo_ticks >= live_cfg.servo_period) begin
        servo_ticks = 0;
        for (int i = 0; i < NUM_SERVOS; i++) servo_compare[i] = servo_shadow[i];
      end
      ppm_ticks++;
      if (ppm_ticks >= slot_len) ppm_ticks = 0;
      if (ppm_ticks == live_cfg.ppm_pulse) begin
        lim = (live_cfg.active_channels > NUM_SLOTS) ? NUM_SLOTS : live_cfg.active_channels;
        if (slot_num < lim) begin
          slot_len = chan_width[slot_num];
          slot_num = (slot_num + 1) & 5'h1F;
        end else begin
          slot_len      = live_cfg.sync_gap;
          slot_num      = 0;
          r.frame_start = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ppmsg_pkg::WIDTH_W-1:0] pick_width();
    int unsigned p;
    int unsigned v;
    int          r;
    p = live_cfg.ppm_pulse;
    r = $urandom_range(0, 99);
    if (r < 70) v = p + $urandom_range(1, 8);
    else if (r < 94) v = $urandom_range(0, p);
    else v = $urandom_range(0, 16'hFFFF);
    return (v > 16'hFFFF) ? 16'hFFFF : v[ppmsg_pkg::WIDTH_W-1:0];
  endfunction

  function automatic ppmsg_pkg::item_t pick_item();
    ppmsg_pkg::item_t it;
    it.req_type = ($urandom_range(0, 99) < 75) ? ppmsg_pkg::REQ_TICK : ppmsg_pkg::REQ_WRITE;
    it.channel  = ppmsg_pkg::CH_W'($urandom_range(0, NUM_SLOTS - 1));
    it.width    = pick_width();
    return it;
  endfunction

  task automatic send_item(ppmsg_pkg::item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= it.req_type;
    in_ch.channel  <= it.channel;
    in_ch.width    <= it.width;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    levels_q.push_back(advance_levels(it));
    @(negedge clk);
  endtask

  task automatic send_ticks(int n);
    ppmsg_pkg::item_t it;
    it.req_type = ppmsg_pkg::REQ_TICK;
    repeat (n) begin
      it.channel = ppmsg_pkg::CH_W'($urandom_range(0, NUM_SLOTS - 1));
      it.width   = ppmsg_pkg::WIDTH_W'($urandom_range(0, 16'hFFFF));
      send_item(it);
    end
  endtask

  task automatic write_chan(logic [ppmsg_pkg::CH_W-1:0] ch, logic [ppmsg_pkg::WIDTH_W-1:0] w);
    ppmsg_pkg::item_t it;
    it.req_type = ppmsg_pkg::REQ_WRITE;
    it.channel  = ch;
    it.width    = w;
    send_item(it);
  endtask

  task automatic settle_block();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (levels_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(logic [ppmsg_pkg::CFG_IDX_W-1:0] idx,
                           logic [ppmsg_pkg::WIDTH_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      ppmsg_pkg::REG_ACTIVE_CHANNELS:
        live_cfg.active_channels = data[ppmsg_pkg::ACT_W-1:0];
      ppmsg_pkg::REG_SYNC_GAP:     live_cfg.sync_gap     = data;
      ppmsg_pkg::REG_PPM_PULSE:    live_cfg.ppm_pulse    = data;
      ppmsg_pkg::REG_SERVO_PERIOD: live_cfg.servo_period = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_reset_values();
    send_ticks(3);
    write_chan(4'd3, 16'd500);
    send_ticks(2);
  endtask

  task automatic test_edge_cases();
    settle_block();
    cfg_write(REG_UNUSED_FIRST, 16'hFFFF);
    cfg_write(REG_UNUSED_LAST, 16'hFFFF);
    cfg_write(ppmsg_pkg::REG_ACTIVE_CHANNELS, 16'd31);
    cfg_write(ppmsg_pkg::REG_SYNC_GAP, 16'd2);
    cfg_write(ppmsg_pkg::REG_PPM_PULSE, 16'd1);
    cfg_write(ppmsg_pkg::REG_SERVO_PERIOD, 16'd0);
    write_chan(4'd0, 16'd3);
    write_chan(4'd1, 16'd0);
    write_chan(4'd15, 16'hFFFF);
    write_chan(4'd12, 16'd7);
    write_chan(4'd11, 16'd0);
    send_ticks(6);
    settle_block();
    cfg_write(ppmsg_pkg::REG_PPM_PULSE, 16'd0);
    cfg_write(ppmsg_pkg::REG_SERVO_PERIOD, 16'hFFFF);
    send_ticks(4);
    settle_block();
    cfg_write(ppmsg_pkg::REG_SERVO_PERIOD, 16'd2);
    send_ticks(3);
    settle_block();
    cfg_write(ppmsg_pkg::REG_PPM_PULSE, 16'd600);
    send_ticks(2);
  endtask

  task automatic set_phase_registers(int p);
    logic [ppmsg_pkg::WIDTH_W-1:0] act;
    logic [ppmsg_pkg::WIDTH_W-1:0] sync;
    logic [ppmsg_pkg::WIDTH_W-1:0] pulse;
    logic [ppmsg_pkg::WIDTH_W-1:0] period;
    act    = ppmsg_pkg::WIDTH_W'($urandom_range(1, 5));
    pulse  = ppmsg_pkg::WIDTH_W'($urandom_range(1, 4));
    sync   = pulse + ppmsg_pkg::WIDTH_W'($urandom_range(1, 8));
    period = ppmsg_pkg::WIDTH_W'($urandom_range(2, 40));
    case (p)
      1: act = '0;
      3: act = ppmsg_pkg::WIDTH_W'($urandom_range(16, 31));
      4: begin
        act    = ppmsg_pkg::WIDTH_W'(NUM_SLOTS);
        sync   = 16'hFFFF;
        pulse  = 16'hFFFF;
        period = 16'hFFFF;
      end
      default: ;
    endcase
    // Keep the frame moving unless the phase tests the largest settings.
    if (p != 4 && slot_len <= pulse)
      pulse = (slot_len >= 2) ? ppmsg_pkg::WIDTH_W'(slot_len - 1) : '0;
    cfg_write(ppmsg_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
              ppmsg_pkg::WIDTH_W'($urandom_range(0, 16'hFFFF)));
    cfg_write(ppmsg_pkg::REG_ACTIVE_CHANNELS, act);
    cfg_write(ppmsg_pkg::REG_SYNC_GAP, sync);
    cfg_write(ppmsg_pkg::REG_PPM_PULSE, pulse);
    cfg_write(ppmsg_pkg::REG_SERVO_PERIOD, period);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      settle_block();
      set_phase_registers(p);
      no_idle = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == PHASE_ITEMS / 2) settle_block();
        send_item(pick_item());
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int stall_left;
    int gap;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = gap - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    levels_t seen;
    levels_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.ppm_level    = out_ch.ppm_level;
      seen.servo_levels = out_ch.servo_levels;
      seen.frame_start  = out_ch.frame_start;
      if (levels_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result item: ppm=%b servo=%03h frame=%b",
                   seen.ppm_level, seen.servo_levels, seen.frame_start);
      end else begin
        want = levels_q.pop_front();
        if (seen.ppm_level !== want.ppm_level || seen.servo_levels !== want.servo_levels ||
            seen.frame_start !== want.frame_start) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: exp ppm=%b servo=%03h frame=%b, got ppm=%b servo=%03h frame=%b",
                     want.ppm_level, want.servo_levels, want.frame_start,
                     seen.ppm_level, seen.servo_levels, seen.frame_start);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL ppm_frame_and_servo_pwm_generator");
        $finish;
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= ppmsg_pkg::REQ_WRITE;
    in_ch.channel  <= '0;
    in_ch.width    <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= ppmsg_pkg::REG_ACTIVE_CHANNELS;
    cfg_ch.data    <= '0;
    reset_levels_model();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_values();
    test_edge_cases();
    test_random_phases();
    settle_block();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && levels_q.size() == 0) begin
      $display("PASS ppm_frame_and_servo_pwm_generator");
    end else begin
      $display("FAIL ppm_frame_and_servo_pwm_generator");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+src
src/ppmsg_pkg.sv
src/ppmsg_ifs.sv
src/ppmsg_servo.sv
src/ppmsg_ppm.sv
src/ppm_frame_and_servo_pwm_generator.sv
src/ppmsg_checker.sv
test/ppm_frame_and_servo_pwm_generator_tb.sv
